// ===== rtl/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types, widths and helpers for the pipelined ray/box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int CW     = 32;           // coordinate width, signed
  localparam int FB     = 16;           // fraction bits
  localparam int NUM_W  = CW + 1;       // exact corner minus origin
  localparam int DVD_W  = NUM_W + FB;   // scaled dividend magnitude, also quotient width
  localparam int DEN_W  = CW;           // divisor magnitude
  localparam int REM_W  = DEN_W;        // partial remainder stays below the divisor
  localparam int NAXIS  = 3;
  localparam int NLANE  = 2 * NAXIS;    // lanes 0..2 use the min corner, 3..5 the max corner

  localparam logic [CW-1:0]    T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]    T_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [DVD_W-1:0] QSIGN = DVD_W'(1) << (CW - 1);

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_min_z;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
    logic signed [CW-1:0] box_max_z;
  } ray_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] t_enter;
    logic signed [CW-1:0] t_exit;
  } res_t;

  // One divider stage: six lanes of remainder and shifting dividend/quotient.
  typedef struct packed {
    logic [NLANE-1:0]             neg;
    logic [NLANE-1:0][REM_W-1:0]  rem;
    logic [NLANE-1:0][DVD_W-1:0]  work;
    logic [NAXIS-1:0][DEN_W-1:0]  den;
    logic [NAXIS-1:0]             dz;
    logic                         pass;
  } div_t;

  // Ordered distances per axis after saturation.
  typedef struct packed {
    logic [NAXIS-1:0][CW-1:0] tn;
    logic [NAXIS-1:0][CW-1:0] tf;
    logic [NAXIS-1:0]         dz;
    logic                     pass;
  } ord_t;

  // Saturate an unsigned quotient magnitude with its sign to a signed result.
  function automatic logic [CW-1:0] sat_quot(input logic [DVD_W-1:0] q, input logic neg);
    logic [CW-1:0] r;
    if (neg) begin
      r = (q >= QSIGN) ? T_MIN : (CW'(0) - q[CW-1:0]);
    end else begin
      r = (q >= QSIGN) ? T_MAX : q[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/rbst_prep.sv =====
// ----------------------------------------------------------------------------
// rbst_prep
// First stage: slab differences, magnitudes, signs and parallel-slab checks.
// ----------------------------------------------------------------------------
module rbst_prep (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  rbst_pkg::ray_t     in_data,
  output logic               out_valid,
  output rbst_pkg::div_t     out_data
);

  logic [rbst_pkg::NAXIS-1:0][rbst_pkg::CW-1:0] org, dir, lo, hi;
  rbst_pkg::div_t prep_next;

  assign org = {in_data.origin_z, in_data.origin_y, in_data.origin_x};
  assign dir = {in_data.dir_z, in_data.dir_y, in_data.dir_x};
  assign lo  = {in_data.box_min_z, in_data.box_min_y, in_data.box_min_x};
  assign hi  = {in_data.box_max_z, in_data.box_max_y, in_data.box_max_x};

  // Per axis: two exact differences, their magnitudes and quotient signs.
  always_comb begin
    logic [rbst_pkg::NUM_W-1:0] dl, dh, ox;
    logic                       in_slab;
    prep_next      = '0;
    prep_next.pass = 1'b1;
    for (int a = 0; a < rbst_pkg::NAXIS; a++) begin
      ox = {org[a][rbst_pkg::CW-1], org[a]};
      dl = {lo[a][rbst_pkg::CW-1], lo[a]} - ox;
      dh = {hi[a][rbst_pkg::CW-1], hi[a]} - ox;
      prep_next.neg[a]   = dl[rbst_pkg::NUM_W-1] ^ dir[a][rbst_pkg::CW-1];
      prep_next.neg[a+3] = dh[rbst_pkg::NUM_W-1] ^ dir[a][rbst_pkg::CW-1];
      prep_next.work[a]   = {(dl[rbst_pkg::NUM_W-1] ? -dl : dl), {rbst_pkg::FB{1'b0}}};
      prep_next.work[a+3] = {(dh[rbst_pkg::NUM_W-1] ? -dh : dh), {rbst_pkg::FB{1'b0}}};
      prep_next.den[a] = dir[a][rbst_pkg::CW-1] ? (rbst_pkg::DEN_W'(0) - dir[a]) : dir[a];
      prep_next.dz[a]  = (dir[a] == '0);
      in_slab = ($signed(org[a]) >= $signed(lo[a])) && ($signed(org[a]) <= $signed(hi[a]));
      if (prep_next.dz[a] && !in_slab) begin
        prep_next.pass = 1'b0;
      end
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= prep_next;
    end
  end

endmodule

// ===== rtl/rbst_div_step.sv =====
// ----------------------------------------------------------------------------
// rbst_div_step
// One restoring-division step for all six lanes, one quotient bit per lane.
// ----------------------------------------------------------------------------
module rbst_div_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  rbst_pkg::div_t     in_data,
  output logic               out_valid,
  output rbst_pkg::div_t     out_data
);

  rbst_pkg::div_t step_next;

  // Shift in the next dividend bit, subtract the divisor when it fits.
  always_comb begin
    logic [rbst_pkg::REM_W:0] trial;
    logic [rbst_pkg::REM_W:0] dext;
    logic                     fit;
    step_next = in_data;
    for (int k = 0; k < rbst_pkg::NLANE; k++) begin
      dext  = {1'b0, in_data.den[k % rbst_pkg::NAXIS]};
      trial = {in_data.rem[k], in_data.work[k][rbst_pkg::DVD_W-1]};
      fit   = (trial >= dext);
      step_next.rem[k]  = fit ? rbst_pkg::REM_W'(trial - dext) : trial[rbst_pkg::REM_W-1:0];
      step_next.work[k] = {in_data.work[k][rbst_pkg::DVD_W-2:0], fit};
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= step_next;
    end
  end

endmodule

// ===== rtl/rbst_post.sv =====
// ----------------------------------------------------------------------------
// rbst_post
// Two stages: saturate and order each slab, then reduce the axes and decide.
// ----------------------------------------------------------------------------
module rbst_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  rbst_pkg::div_t     in_data,
  output logic               out_valid,
  output rbst_pkg::res_t     out_data
);

  rbst_pkg::ord_t ord_next, ord;
  rbst_pkg::res_t res_next;
  logic           ord_valid;

  // Saturate both quotients of each axis and order them.
  always_comb begin
    logic [rbst_pkg::CW-1:0] t1, t2;
    ord_next.dz   = in_data.dz;
    ord_next.pass = in_data.pass;
    for (int a = 0; a < rbst_pkg::NAXIS; a++) begin
      t1 = rbst_pkg::sat_quot(in_data.work[a], in_data.neg[a]);
      t2 = rbst_pkg::sat_quot(in_data.work[a+3], in_data.neg[a+3]);
      if ($signed(t1) < $signed(t2)) begin
        ord_next.tn[a] = t1;
        ord_next.tf[a] = t2;
      end else begin
        ord_next.tn[a] = t2;
        ord_next.tf[a] = t1;
      end
    end
  end

  // Largest entry and smallest exit over the bounding axes, then the hit test.
  always_comb begin
    logic [rbst_pkg::CW-1:0] ent, ext;
    ent = rbst_pkg::T_MIN;
    ext = rbst_pkg::T_MAX;
    for (int a = 0; a < rbst_pkg::NAXIS; a++) begin
      if (!ord.dz[a] && ($signed(ord.tn[a]) > $signed(ent))) begin
        ent = ord.tn[a];
      end
      if (!ord.dz[a] && ($signed(ord.tf[a]) < $signed(ext))) begin
        ext = ord.tf[a];
      end
    end
    res_next.t_enter = ent;
    res_next.t_exit  = ext;
    res_next.hit     = ord.pass && ($signed(ent) <= $signed(ext)) && !ext[rbst_pkg::CW-1];
  end

  // Stage registers; the second one is the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ord_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      ord_valid <= in_valid;
      out_valid <= ord_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ord      <= ord_next;
      out_data <= res_next;
    end
  end

endmodule

// ===== rtl/ray_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Pipelined ray versus axis-aligned box slab test in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
// A ray/box beat enters on ray (ray_valid/ray_ready) and its verdict leaves on
// res (res_valid/res_ready): hit plus the saturated entry and exit distances.
// The pipeline has 52 register stages: one for the slab differences, 49 for
// the six parallel restoring dividers (one quotient bit per stage), one to
// saturate and order each slab and one to reduce the axes into the result,
// which is the output register. One beat per cycle is taken and delivered
// in steady state while res_ready is high.
// When res_ready is low with a result waiting, the whole pipeline holds and
// ray_ready drops; nothing is dropped or repeated. Reset clears every stage
// valid bit, so res_valid is low and ray_ready high right after reset.
// ----------------------------------------------------------------------------
module ray_box_slab_test (
  input  logic              clk,
  input  logic              rst,
  input  logic              ray_valid,
  output logic              ray_ready,
  input  rbst_pkg::ray_t    ray,
  output logic              res_valid,
  input  logic              res_ready,
  output rbst_pkg::res_t    res
);

  localparam int NSTEP = rbst_pkg::DVD_W;

  logic                 en;
  logic [NSTEP:0]       dv_valid;
  rbst_pkg::div_t       dv_data [NSTEP+1];

  // The pipeline advances unless a finished result is being held.
  assign en        = !res_valid || res_ready;
  assign ray_ready = en;

  rbst_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ray_valid),
    .in_data   (ray),
    .out_valid (dv_valid[0]),
    .out_data  (dv_data[0])
  );

  // Divider chain, one quotient bit per stage.
  for (genvar s = 0; s < NSTEP; s++) begin : g_div
    rbst_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_valid[s]),
      .in_data   (dv_data[s]),
      .out_valid (dv_valid[s+1]),
      .out_data  (dv_data[s+1])
    );
  end

  rbst_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv_valid[NSTEP]),
    .in_data   (dv_data[NSTEP]),
    .out_valid (res_valid),
    .out_data  (res)
  );

`ifndef SYNTHESIS
  // A hit always has an ordered, non-negative interval.
  a_hit_interval: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.hit |-> ($signed(res.t_enter) <= $signed(res.t_exit)) &&
      !res.t_exit[rbst_pkg::CW-1])
    else $error("hit reported with an empty or negative interval");

  // A result disappears only after it was taken.
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(res_valid) |-> $past(res_ready))
    else $error("result dropped without being taken");

  // While the output stalls, the first divider stage holds its beat.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    $past(res_valid && !res_ready) && !$past(rst) |-> $stable(dv_valid[1]))
    else $error("pipeline moved during a stall");

  // Reset leaves the output empty.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== dv/ray_box_slab_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_box_slab_check
// Watches the ray and result channels of the slab test, works out the
// expected verdict of every accepted ray beat and compares it with the
// result beats in order.
// ----------------------------------------------------------------------------
module ray_box_slab_check (
  input  logic            clk,
  input  logic            rst,
  input  logic            ray_valid,
  input  logic            ray_ready,
  input  rbst_pkg::ray_t  ray,
  input  logic            res_valid,
  input  logic            res_ready,
  input  rbst_pkg::res_t  res,
  output int              fail_count,
  output int              pending,
  output int              verdicts_seen,
  output int              hits_seen
);

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  rbst_pkg::res_t verdict_q[$];

  // Signed fixed-point quotient (num * 2^16) / den, truncated toward zero,
  // then clamped to the 32-bit signed range. The divisor is never zero.
  function automatic longint slab_dist(input longint num, input longint den);
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    logic         neg;
    longint       r;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? 128'(-num) : 128'(num);
    d = (den < 0) ? 128'(-den) : 128'(den);
    q = (n << rbst_pkg::FB) / d;
    if (neg) begin
      r = (q > 128'(-SAT_LO)) ? SAT_LO : -longint'(q);
    end else begin
      r = (q > 128'(SAT_HI)) ? SAT_HI : longint'(q);
    end
    return r;
  endfunction

  // Verdict for one ray beat: latest entry, earliest exit and hit.
  function automatic rbst_pkg::res_t slab_verdict(input rbst_pkg::ray_t b);
    logic signed [rbst_pkg::CW-1:0] o[3];
    logic signed [rbst_pkg::CW-1:0] d[3];
    logic signed [rbst_pkg::CW-1:0] lo[3];
    logic signed [rbst_pkg::CW-1:0] hi[3];
    longint t1, t2, tn, tf, ent, ext;
    logic   inside_all;
    rbst_pkg::res_t v;
    o  = '{b.origin_x, b.origin_y, b.origin_z};
    d  = '{b.dir_x, b.dir_y, b.dir_z};
    lo = '{b.box_min_x, b.box_min_y, b.box_min_z};
    hi = '{b.box_max_x, b.box_max_y, b.box_max_z};
    ent = SAT_LO;
    ext = SAT_HI;
    inside_all = 1'b1;
    for (int a = 0; a < rbst_pkg::NAXIS; a++) begin
      if (d[a] == 0) begin
        // A parallel slab only passes when the origin lies inside it.
        if (o[a] < lo[a] || o[a] > hi[a]) inside_all = 1'b0;
      end else begin
        t1 = slab_dist(longint'(lo[a]) - longint'(o[a]), longint'(d[a]));
        t2 = slab_dist(longint'(hi[a]) - longint'(o[a]), longint'(d[a]));
        tn = (t1 < t2) ? t1 : t2;
        tf = (t1 < t2) ? t2 : t1;
        if (tn > ent) ent = tn;
        if (tf < ext) ext = tf;
      end
    end
    v.hit = inside_all && ent <= ext && ext >= 0;
    v.t_enter = rbst_pkg::CW'(ent);
    v.t_exit = rbst_pkg::CW'(ext);
    return v;
  endfunction

  assign pending = verdict_q.size();

  // Predict on every accepted ray beat and compare on every result beat.
  always @(posedge clk) begin
    rbst_pkg::res_t want;
    int             errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      verdicts_seen <= 0;
      hits_seen <= 0;
      verdict_q.delete();
    end else begin
      if (ray_valid && ray_ready) verdict_q = {verdict_q, slab_verdict(ray)};
      if (res_valid && res_ready) begin
        verdicts_seen <= verdicts_seen + 1;
        if (res.hit) hits_seen <= hits_seen + 1;
        if (verdict_q.size() == 0) begin
          $error("result beat with no ray waiting: %p", res);
          errs++;
        end else begin
          want = verdict_q.pop_front();
          if (res.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, res.hit);
            errs++;
          end
          if (res.t_enter !== want.t_enter) begin
            $error("t_enter: expected %0d, got %0d", want.t_enter, res.t_enter);
            errs++;
          end
          if (res.t_exit !== want.t_exit) begin
            $error("t_exit: expected %0d, got %0d", want.t_exit, res.t_exit);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== dv/ray_box_slab_test_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_test
// Drives directed and random rays and boxes into the slab test with random
// gaps and result stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module ray_box_slab_test_test;

  localparam int RANDOM_RAYS = 680;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic ray_valid = 1'b0;
  logic ray_ready;
  rbst_pkg::ray_t ray = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  rbst_pkg::res_t res;
  int   fail_count, pending, verdicts_seen, hits_seen;
  int   cycle_count = 0;
  bit   calm = 1'b0;
  int   rays_sent = 0;

  ray_box_slab_test u_dut (
    .clk(clk), .rst(rst), .ray_valid(ray_valid), .ray_ready(ray_ready), .ray(ray),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  ray_box_slab_check u_check (
    .clk(clk), .rst(rst), .ray_valid(ray_valid), .ray_ready(ray_ready), .ray(ray),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .fail_count(fail_count), .pending(pending), .verdicts_seen(verdicts_seen),
    .hits_seen(hits_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side drops res_ready with a chance of 13 in a hundred unless in a calm stretch.
  always @(negedge clk) begin
    res_ready <= calm || ($urandom_range(99) >= 13);
  end

  // Hard limit on run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ray_box_slab_test_test: errors");
      $finish;
    end
  end

  // Present one ray beat and hold it until accepted; valid only drops in a gap.
  task automatic send_ray(input rbst_pkg::ray_t b);
    while (!calm && $urandom_range(99) < 13) begin
      ray_valid <= 1'b0;
      @(negedge clk);
    end
    ray_valid <= 1'b1;
    ray <= b;
    @(posedge clk);
    while (!ray_ready) @(posedge clk);
    @(negedge clk);
    rays_sent++;
  endtask

  function automatic logic [rbst_pkg::CW-1:0] any_word();
    case ($urandom_range(5))
      0: return rbst_pkg::T_MAX;
      1: return rbst_pkg::T_MIN;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Random box around a nearby origin with a ray that mostly points inward.
  function automatic rbst_pkg::ray_t aimed_ray();
    rbst_pkg::ray_t b;
    logic signed [rbst_pkg::CW-1:0] c[3], h[3], o[3], d[3];
    for (int a = 0; a < 3; a++) begin
      c[a] = $signed(rbst_pkg::CW'($urandom_range(65536 * 64))) - (32 * 65536);
      h[a] = rbst_pkg::CW'($urandom_range(65536 * 8));
      o[a] = c[a] + $signed(rbst_pkg::CW'($urandom_range(65536 * 64))) - (32 * 65536);
      d[a] = ($urandom_range(9) == 0) ? '0 :
             (c[a] - o[a]) / 16 + $signed(rbst_pkg::CW'($urandom_range(4095))) - 2048;
    end
    b.origin_x = o[0]; b.origin_y = o[1]; b.origin_z = o[2];
    b.dir_x = d[0]; b.dir_y = d[1]; b.dir_z = d[2];
    b.box_min_x = c[0] - h[0]; b.box_min_y = c[1] - h[1]; b.box_min_z = c[2] - h[2];
    b.box_max_x = c[0] + h[0]; b.box_max_y = c[1] + h[1]; b.box_max_z = c[2] + h[2];
    return b;
  endfunction

  function automatic rbst_pkg::ray_t wild_ray();
    rbst_pkg::ray_t b;
    b.origin_x = any_word(); b.origin_y = any_word(); b.origin_z = any_word();
    b.dir_x = any_word(); b.dir_y = any_word(); b.dir_z = any_word();
    b.box_min_x = any_word(); b.box_min_y = any_word(); b.box_min_z = any_word();
    b.box_max_x = any_word(); b.box_max_y = any_word(); b.box_max_z = any_word();
    return b;
  endfunction

  // Axis-symmetric ray for directed cases.
  function automatic rbst_pkg::ray_t even_ray(input logic [rbst_pkg::CW-1:0] o,
                                              input logic [rbst_pkg::CW-1:0] d,
                                              input logic [rbst_pkg::CW-1:0] lo,
                                              input logic [rbst_pkg::CW-1:0] hi);
    rbst_pkg::ray_t b;
    b.origin_x = o; b.origin_y = o; b.origin_z = o;
    b.dir_x = d; b.dir_y = d; b.dir_z = d;
    b.box_min_x = lo; b.box_min_y = lo; b.box_min_z = lo;
    b.box_max_x = hi; b.box_max_y = hi; b.box_max_z = hi;
    return b;
  endfunction

  initial begin
    rbst_pkg::ray_t b;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: plain hit, miss behind, extremes, parallel slabs, inverted box.
    send_ray(even_ray(32'sh0, 32'sh10000, 32'sh20000, 32'sh30000));
    send_ray(even_ray(32'sh0, -32'sh10000, 32'sh20000, 32'sh30000));
    send_ray(even_ray(rbst_pkg::T_MIN, 32'sh1, rbst_pkg::T_MAX, rbst_pkg::T_MAX));
    send_ray(even_ray(rbst_pkg::T_MAX, rbst_pkg::T_MIN, rbst_pkg::T_MIN, rbst_pkg::T_MAX));
    send_ray(even_ray(rbst_pkg::T_MIN, rbst_pkg::T_MAX, rbst_pkg::T_MIN, rbst_pkg::T_MAX));
    send_ray(even_ray(rbst_pkg::T_MAX, -32'sh1, rbst_pkg::T_MIN, rbst_pkg::T_MIN));
    send_ray(even_ray(32'sh0, 32'sh0, -32'sh10000, 32'sh10000));
    send_ray(even_ray(32'sh50000, 32'sh0, -32'sh10000, 32'sh10000));
    send_ray(even_ray(32'sh0, 32'sh10000, 32'sh30000, 32'sh20000));
    send_ray(even_ray(32'sh0, 32'sh0, 32'sh10000, -32'sh10000));
    send_ray(even_ray(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
    b = even_ray(32'sh0, 32'sh10000, -32'sh10000, 32'sh10000);
    b.dir_y = '0;
    send_ray(b);
    b.origin_y = 32'sh40000;
    send_ray(b);
    b = even_ray(-32'sh80000, 32'sh0, -32'sh10000, 32'sh10000);
    b.dir_z = 32'sh10000;
    send_ray(b);
    ray_valid <= 1'b0;

    // Let everything drain before the random part.
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < RANDOM_RAYS; i++) begin
      calm = (i >= 200 && i < 300);
      send_ray(($urandom_range(3) == 0) ? wild_ray() : aimed_ray());
    end
    calm = 1'b0;
    ray_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d rays; %0d verdicts checked, %0d of them hits.",
             rays_sent, verdicts_seen, hits_seen);
    if (fail_count == 0) begin
      $display("ray_box_slab_test_test: clean");
    end else begin
      $display("ray_box_slab_test_test: errors");
    end
    $finish;
  end

endmodule
